FILE: design/njs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package njs_pkg;

   // Default width of the countdown timer
   localparam int TIMER_BITS_DEFAULT = 16;

   // Event codes on the request channel
   typedef enum logic [2:0] {
      FN_TICK          = 3'd0,
      FN_RESET_IND     = 3'd1,
      FN_INFO_REPLY    = 3'd2,
      FN_WRITE_REPLY   = 3'd3,
      FN_ZDO_STATUS    = 3'd4,
      FN_FACTORY_RESET = 3'd5,
      FN_RESTART       = 3'd6
   } func_type;

   // Commands toward the coprocessor
   typedef enum logic [2:0] {
      CMD_NONE       = 3'd0,
      CMD_GET_INFO   = 3'd1,
      CMD_WRITE_TYPE = 3'd2,
      CMD_START_NET  = 3'd3,
      CMD_SYS_RESET  = 3'd4
   } command_type;

   // LED patterns
   typedef enum logic [1:0] {
      LED_NONE    = 2'd0,
      LED_FACTORY = 2'd1,
      LED_ON_NET  = 2'd2,
      LED_FAILURE = 2'd3
   } led_type;

   // Join state
   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_INFO    = 3'd1,
      ST_WRITE   = 3'd2,
      ST_START   = 3'd3,
      ST_ON_NET  = 3'd4,
      ST_RECOVER = 3'd5
   } join_state_type;

   // Register indexes of the csr port
   localparam logic [2:0] REG_WANTED_TYPE   = 3'd0;
   localparam logic [2:0] REG_RESPONSE_WAIT = 3'd1;
   localparam logic [2:0] REG_RESET_WAIT    = 3'd2;
   localparam logic [2:0] REG_JOIN_WAIT     = 3'd3;
   localparam logic [2:0] REG_RETRY_WAIT    = 3'd4;
   localparam logic [2:0] REG_RETRY_LIMIT   = 3'd5;
   localparam logic [2:0] REG_START_MODE    = 3'd6;

   // Register reset values
   localparam logic [7:0]  WANTED_TYPE_RST   = 8'h00;
   localparam logic [15:0] RESPONSE_WAIT_RST = 16'd500;
   localparam logic [15:0] RESET_WAIT_RST    = 16'd5000;
   localparam logic [15:0] JOIN_WAIT_RST     = 16'd10000;
   localparam logic [15:0] RETRY_WAIT_RST    = 16'd5000;
   localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd10;
   localparam logic [7:0]  START_MODE_RST    = 8'h02;

   localparam logic [7:0]  ERR_MAX           = 8'hFF;
   localparam logic [7:0]  NOT_STARTED       = 8'h00;
   localparam logic [7:0]  STATUS_OK         = 8'h00;

endpackage

`default_nettype wire

FILE: design/network_join_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Join sequencer for a radio coprocessor. Every request beat (tick, reset
// indication, info reply, write reply, zdo status, factory reset, restart)
// produces exactly one response beat carrying the command to send, its
// argument, an LED pattern, the join state after the event and the latched
// network identity. The decision is one pass of logic on registered state,
// so a request is taken every cycle: response beat appears the cycle after
// the request is accepted, and the only thing that can hold off req is a
// response still sitting in the output register while rsp_stall is high.
// The countdown timer is TIMER_BITS wide; wait values are truncated to that
// width when the timer is loaded. After reset the timer runs from reset_wait.

module network_join_sequencer #(
   parameter int TIMER_BITS = njs_pkg::TIMER_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [7:0]  req_reported_type,
   input  wire logic [7:0]  req_net_started,
   input  wire logic [15:0] req_node_addr,
   input  wire logic [63:0] req_node_mac,
   input  wire logic [15:0] req_coord_addr,
   input  wire logic [63:0] req_coord_mac,
   input  wire logic [7:0]  req_radio_channel,
   input  wire logic [15:0] req_pan_ident,
   input  wire logic [7:0]  req_status_code,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_command,
   output logic [7:0]       rsp_command_arg,
   output logic [1:0]       rsp_led_pattern,
   output logic [2:0]       rsp_join_state,
   output logic             rsp_on_net,
   output logic [7:0]       rsp_error_count,
   output logic [15:0]      rsp_my_short_addr,
   output logic [63:0]      rsp_my_ext_addr,
   output logic [15:0]      rsp_parent_short_addr,
   output logic [63:0]      rsp_parent_ext_addr,
   output logic [7:0]       rsp_chan_out,
   output logic [15:0]      rsp_pan_out,
   // configuration
   input  wire logic        csr_write_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [7:0]  wanted_type_ff;
   logic [15:0] response_wait_ff;
   logic [15:0] reset_wait_ff;
   logic [15:0] join_wait_ff;
   logic [15:0] retry_wait_ff;
   logic [7:0]  retry_limit_ff;
   logic [7:0]  start_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_type_ff   <= njs_pkg::WANTED_TYPE_RST;
         response_wait_ff <= njs_pkg::RESPONSE_WAIT_RST;
         reset_wait_ff    <= njs_pkg::RESET_WAIT_RST;
         join_wait_ff     <= njs_pkg::JOIN_WAIT_RST;
         retry_wait_ff    <= njs_pkg::RETRY_WAIT_RST;
         retry_limit_ff   <= njs_pkg::RETRY_LIMIT_RST;
         start_mode_ff    <= njs_pkg::START_MODE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            njs_pkg::REG_WANTED_TYPE:   wanted_type_ff   <= csr_wdata[7:0];
            njs_pkg::REG_RESPONSE_WAIT: response_wait_ff <= csr_wdata;
            njs_pkg::REG_RESET_WAIT:    reset_wait_ff    <= csr_wdata;
            njs_pkg::REG_JOIN_WAIT:     join_wait_ff     <= csr_wdata;
            njs_pkg::REG_RETRY_WAIT:    retry_wait_ff    <= csr_wdata;
            njs_pkg::REG_RETRY_LIMIT:   retry_limit_ff   <= csr_wdata[7:0];
            njs_pkg::REG_START_MODE:    start_mode_ff    <= csr_wdata[7:0];
            default: ;  // unused index: write is dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: output register frees up when empty or being drained, so a
   // new beat can be taken in the same cycle the old one leaves.
   // ---------------------------------------------------------------------
   logic req_accept;
   logic rsp_valid_ff;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Sequencer state
   // ---------------------------------------------------------------------
   njs_pkg::join_state_type link_state_ff, link_state_in;
   logic                    info_valid_ff, info_valid_in;
   logic [7:0]              err_count_ff, err_count_in;
   logic [TIMER_BITS-1:0]   countdown_ff, countdown_in;
   logic                    running_ff, running_in;
   logic [15:0]             held_short_ff, held_short_in;
   logic [63:0]             held_ext_ff, held_ext_in;
   logic [15:0]             held_parent_short_ff, held_parent_short_in;
   logic [63:0]             held_parent_ext_ff, held_parent_ext_in;
   logic [7:0]              held_channel_ff, held_channel_in;
   logic [15:0]             held_pan_ff, held_pan_in;

   // result registers for the per-event fields
   njs_pkg::command_type    command_ff, command_in;
   logic [7:0]              command_arg_ff, command_arg_in;
   njs_pkg::led_type        led_ff, led_in;

   logic [7:0]              err_bumped;

   // saturating increment, shared by expiry and failed write
   assign err_bumped = (err_count_ff == njs_pkg::ERR_MAX) ? err_count_ff
                                                          : err_count_ff + 8'd1;

   always_comb begin
      link_state_in        = link_state_ff;
      info_valid_in        = info_valid_ff;
      err_count_in         = err_count_ff;
      countdown_in         = countdown_ff;
      running_in           = running_ff;
      held_short_in        = held_short_ff;
      held_ext_in          = held_ext_ff;
      held_parent_short_in = held_parent_short_ff;
      held_parent_ext_in   = held_parent_ext_ff;
      held_channel_in      = held_channel_ff;
      held_pan_in          = held_pan_ff;
      command_in           = njs_pkg::CMD_NONE;
      command_arg_in       = 8'h00;
      led_in               = njs_pkg::LED_NONE;

      case (req_func)
         njs_pkg::FN_TICK: begin
            if (running_ff) begin
               if (countdown_ff > TIMER_BITS'(1)) begin
                  countdown_in = countdown_ff - TIMER_BITS'(1);
               end else begin
                  // expiry (a zero count also lands here)
                  countdown_in = '0;
                  running_in   = 1'b0;
                  err_count_in = err_bumped;
                  if (err_bumped > retry_limit_ff) begin
                     link_state_in = njs_pkg::ST_IDLE;
                     led_in        = njs_pkg::LED_FAILURE;
                  end else if (link_state_ff == njs_pkg::ST_START ||
                               link_state_ff == njs_pkg::ST_RECOVER) begin
                     command_in     = njs_pkg::CMD_START_NET;
                     command_arg_in = start_mode_ff;
                     countdown_in   = TIMER_BITS'(join_wait_ff);
                     running_in     = 1'b1;
                  end else begin
                     command_in    = njs_pkg::CMD_GET_INFO;
                     link_state_in = njs_pkg::ST_INFO;
                     countdown_in  = TIMER_BITS'(response_wait_ff);
                     running_in    = 1'b1;
                  end
               end
            end
         end
         njs_pkg::FN_RESET_IND: begin
            command_in    = njs_pkg::CMD_GET_INFO;
            link_state_in = njs_pkg::ST_INFO;
            countdown_in  = TIMER_BITS'(response_wait_ff);
            running_in    = 1'b1;
         end
         njs_pkg::FN_INFO_REPLY: begin
            if (req_reported_type != wanted_type_ff) begin
               command_in     = njs_pkg::CMD_WRITE_TYPE;
               command_arg_in = wanted_type_ff;
               link_state_in  = njs_pkg::ST_WRITE;
               countdown_in   = TIMER_BITS'(response_wait_ff);
               running_in     = 1'b1;
            end else if (req_net_started == njs_pkg::NOT_STARTED) begin
               command_in     = njs_pkg::CMD_START_NET;
               command_arg_in = start_mode_ff;
               link_state_in  = njs_pkg::ST_START;
               countdown_in   = TIMER_BITS'(join_wait_ff);
               running_in     = 1'b1;
            end else begin
               // on the network: latch identity, stop the timer
               held_short_in        = req_node_addr;
               held_ext_in          = req_node_mac;
               held_parent_short_in = req_coord_addr;
               held_parent_ext_in   = req_coord_mac;
               held_channel_in      = req_radio_channel;
               held_pan_in          = req_pan_ident;
               link_state_in        = njs_pkg::ST_ON_NET;
               info_valid_in        = 1'b1;
               running_in           = 1'b0;
               led_in               = njs_pkg::LED_ON_NET;
            end
         end
         njs_pkg::FN_WRITE_REPLY: begin
            if (req_status_code != njs_pkg::STATUS_OK) begin
               err_count_in = err_bumped;
            end
            command_in    = njs_pkg::CMD_SYS_RESET;
            link_state_in = njs_pkg::ST_IDLE;
            countdown_in  = TIMER_BITS'(reset_wait_ff);
            running_in    = 1'b1;
         end
         njs_pkg::FN_ZDO_STATUS: begin
            if (req_status_code == njs_pkg::STATUS_OK) begin
               command_in    = njs_pkg::CMD_GET_INFO;
               link_state_in = njs_pkg::ST_INFO;
               countdown_in  = TIMER_BITS'(response_wait_ff);
            end else begin
               link_state_in = njs_pkg::ST_RECOVER;
               countdown_in  = TIMER_BITS'(retry_wait_ff);
            end
            running_in = 1'b1;
         end
         njs_pkg::FN_FACTORY_RESET: begin
            // timer is left alone
            link_state_in = njs_pkg::ST_IDLE;
            info_valid_in = 1'b0;
            led_in        = njs_pkg::LED_FACTORY;
         end
         njs_pkg::FN_RESTART: begin
            link_state_in = njs_pkg::ST_IDLE;
            info_valid_in = 1'b0;
            err_count_in  = 8'h00;
            command_in    = njs_pkg::CMD_SYS_RESET;
            countdown_in  = TIMER_BITS'(reset_wait_ff);
            running_in    = 1'b1;
         end
         default: ;  // unused code: nothing changes, no command
      endcase
   end

   // state registers move only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         link_state_ff        <= njs_pkg::ST_IDLE;
         info_valid_ff        <= 1'b0;
         err_count_ff         <= 8'h00;
         countdown_ff         <= TIMER_BITS'(njs_pkg::RESET_WAIT_RST);
         running_ff           <= 1'b1;
         held_short_ff        <= '0;
         held_ext_ff          <= '0;
         held_parent_short_ff <= '0;
         held_parent_ext_ff   <= '0;
         held_channel_ff      <= '0;
         held_pan_ff          <= '0;
      end else if (req_accept) begin
         link_state_ff        <= link_state_in;
         info_valid_ff        <= info_valid_in;
         err_count_ff         <= err_count_in;
         countdown_ff         <= countdown_in;
         running_ff           <= running_in;
         held_short_ff        <= held_short_in;
         held_ext_ff          <= held_ext_in;
         held_parent_short_ff <= held_parent_short_in;
         held_parent_ext_ff   <= held_parent_ext_in;
         held_channel_ff      <= held_channel_in;
         held_pan_ff          <= held_pan_in;
      end
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // per-event result fields; no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         command_ff     <= command_in;
         command_arg_ff <= command_arg_in;
         led_ff         <= led_in;
      end
   end

   // State fields come straight from the state registers: they can only
   // change on an accept, which needs the response slot to be free, so they
   // always match the beat that sits in the output register.
   assign rsp_command           = command_ff;
   assign rsp_command_arg       = command_arg_ff;
   assign rsp_led_pattern       = led_ff;
   assign rsp_join_state        = link_state_ff;
   assign rsp_on_net            = (link_state_ff == njs_pkg::ST_ON_NET) & info_valid_ff;
   assign rsp_error_count       = err_count_ff;
   assign rsp_my_short_addr     = held_short_ff;
   assign rsp_my_ext_addr       = held_ext_ff;
   assign rsp_parent_short_addr = held_parent_short_ff;
   assign rsp_parent_ext_addr   = held_parent_ext_ff;
   assign rsp_chan_out          = held_channel_ff;
   assign rsp_pan_out           = held_pan_ff;

endmodule

`default_nettype wire

FILE: design/njs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module njs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_command,
   input wire logic [7:0]  rsp_command_arg,
   input wire logic [1:0]  rsp_led_pattern,
   input wire logic [2:0]  rsp_join_state,
   input wire logic        rsp_on_net,
   input wire logic [7:0]  rsp_error_count
);

   // every accepted request yields a response beat next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request produced no response beat");

   // stalled response holds its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_command) &&
         $stable(rsp_command_arg) && $stable(rsp_join_state) &&
         $stable(rsp_error_count)))
      else $error("stalled response beat changed");

   a_on_net_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_on_net) |-> (rsp_join_state == njs_pkg::ST_ON_NET))
      else $error("on_net set outside the on-net state");

   a_arg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_command != njs_pkg::CMD_WRITE_TYPE &&
       rsp_command != njs_pkg::CMD_START_NET) |-> (rsp_command_arg == 8'h00))
      else $error("command argument set on a command without one");

   a_failure_gives_up: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_led_pattern == njs_pkg::LED_FAILURE) |->
         (rsp_join_state == njs_pkg::ST_IDLE && rsp_command == njs_pkg::CMD_NONE &&
          rsp_error_count != 8'h00))
      else $error("failure pattern without giving up");

endmodule

bind network_join_sequencer njs_checker u_njs_checker (.*);

`default_nettype wire

FILE: test/network_join_sequencer_test.sv
`timescale 1ns / 1ps

module network_join_sequencer_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 120;      // long response hold-off
   localparam logic [2:0] FN_UNUSED = 3'd7;

   // one request beat
   typedef struct {
      logic [2:0]  func;
      logic [7:0]  reported_type;
      logic [7:0]  net_started;
      logic [15:0] node_addr;
      logic [63:0] node_mac;
      logic [15:0] coord_addr;
      logic [63:0] coord_mac;
      logic [7:0]  radio_channel;
      logic [15:0] pan_ident;
      logic [7:0]  status_code;
   } join_event_type;

   // one response beat
   typedef struct {
      njs_pkg::command_type    command;
      logic [7:0]              command_arg;
      njs_pkg::led_type        led;
      njs_pkg::join_state_type join_state;
      logic                    on_net;
      logic [7:0]              error_count;
      logic [15:0]             my_short;
      logic [63:0]             my_ext;
      logic [15:0]             parent_short;
      logic [63:0]             parent_ext;
      logic [7:0]              channel;
      logic [15:0]             pan;
   } join_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = njs_pkg::FN_TICK;
   logic [7:0]  req_reported_type = '0;
   logic [7:0]  req_net_started = '0;
   logic [15:0] req_node_addr = '0;
   logic [63:0] req_node_mac = '0;
   logic [15:0] req_coord_addr = '0;
   logic [63:0] req_coord_mac = '0;
   logic [7:0]  req_radio_channel = '0;
   logic [15:0] req_pan_ident = '0;
   logic [7:0]  req_status_code = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_command;
   logic [7:0]  rsp_command_arg;
   logic [1:0]  rsp_led_pattern;
   logic [2:0]  rsp_join_state;
   logic        rsp_on_net;
   logic [7:0]  rsp_error_count;
   logic [15:0] rsp_my_short_addr;
   logic [63:0] rsp_my_ext_addr;
   logic [15:0] rsp_parent_short_addr;
   logic [63:0] rsp_parent_ext_addr;
   logic [7:0]  rsp_chan_out;
   logic [15:0] rsp_pan_out;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = njs_pkg::REG_WANTED_TYPE;
   logic [15:0] csr_wdata = '0;

   network_join_sequencer dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_func              (req_func),
      .req_reported_type     (req_reported_type),
      .req_net_started       (req_net_started),
      .req_node_addr         (req_node_addr),
      .req_node_mac          (req_node_mac),
      .req_coord_addr        (req_coord_addr),
      .req_coord_mac         (req_coord_mac),
      .req_radio_channel     (req_radio_channel),
      .req_pan_ident         (req_pan_ident),
      .req_status_code       (req_status_code),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_command           (rsp_command),
      .rsp_command_arg       (rsp_command_arg),
      .rsp_led_pattern       (rsp_led_pattern),
      .rsp_join_state        (rsp_join_state),
      .rsp_on_net            (rsp_on_net),
      .rsp_error_count       (rsp_error_count),
      .rsp_my_short_addr     (rsp_my_short_addr),
      .rsp_my_ext_addr       (rsp_my_ext_addr),
      .rsp_parent_short_addr (rsp_parent_short_addr),
      .rsp_parent_ext_addr   (rsp_parent_ext_addr),
      .rsp_chan_out          (rsp_chan_out),
      .rsp_pan_out           (rsp_pan_out),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Sequencer shadow: configuration, join state, timer, identity
   // ---------------------------------------------------------------
   logic [7:0]     cfg_wanted_type;
   logic [15:0]    cfg_response_wait;
   logic [15:0]    cfg_reset_wait;
   logic [15:0]    cfg_join_wait;
   logic [15:0]    cfg_retry_wait;
   logic [7:0]     cfg_retry_limit;
   logic [7:0]     cfg_start_mode;

   njs_pkg::join_state_type link;
   logic           info_valid;
   logic [7:0]     err_count;
   logic [15:0]    tmr_count;
   logic           tmr_running;
   logic [15:0]    id_short;
   logic [63:0]    id_ext;
   logic [15:0]    id_parent_short;
   logic [63:0]    id_parent_ext;
   logic [7:0]     id_channel;
   logic [15:0]    id_pan;

   join_report_type pending_reports[$];   // one per accepted request, oldest first

   int send_idle_pct = 6;   // chance the sender skips a cycle
   int stall_pct = 72;      // chance the receiver stalls a cycle
   logic hold_active = 1'b0;
   event hold_go;

   int failures = 0;
   int events_sent = 0;
   int reports_checked = 0;
   int on_net_reports = 0;
   int give_up_reports = 0;
   int peak_errors = 0;
   int cycle_count = 0;

   // timer is 16 bits wide here, so a load needs no masking
   function automatic void arm_timer(input logic [15:0] ticks);
      tmr_count = ticks;
      tmr_running = 1'b1;
   endfunction

   function automatic void bump_errors();
      if (err_count != njs_pkg::ERR_MAX)
         err_count = err_count + 8'd1;
   endfunction

   function automatic void reset_sequencer_model();
      cfg_wanted_type = njs_pkg::WANTED_TYPE_RST;
      cfg_response_wait = njs_pkg::RESPONSE_WAIT_RST;
      cfg_reset_wait = njs_pkg::RESET_WAIT_RST;
      cfg_join_wait = njs_pkg::JOIN_WAIT_RST;
      cfg_retry_wait = njs_pkg::RETRY_WAIT_RST;
      cfg_retry_limit = njs_pkg::RETRY_LIMIT_RST;
      cfg_start_mode = njs_pkg::START_MODE_RST;
      link = njs_pkg::ST_IDLE;
      info_valid = 1'b0;
      err_count = '0;
      arm_timer(njs_pkg::RESET_WAIT_RST);
      id_short = '0;
      id_ext = '0;
      id_parent_short = '0;
      id_parent_ext = '0;
      id_channel = '0;
      id_pan = '0;
   endfunction

   // Apply one event to the shadow state and return the beat it yields.
   function automatic join_report_type advance_join(input join_event_type ev);
      join_report_type r;
      r.command = njs_pkg::CMD_NONE;
      r.command_arg = '0;
      r.led = njs_pkg::LED_NONE;
      case (ev.func)
         njs_pkg::FN_TICK: begin
            if (tmr_running) begin
               if (tmr_count > 16'd1) begin
                  tmr_count = tmr_count - 16'd1;
               end else begin
                  // expiry: a zero load lands here on the first tick too
                  tmr_count = '0;
                  tmr_running = 1'b0;
                  bump_errors();
                  if (err_count > cfg_retry_limit) begin
                     link = njs_pkg::ST_IDLE;
                     r.led = njs_pkg::LED_FAILURE;
                  end else if (link == njs_pkg::ST_START ||
                               link == njs_pkg::ST_RECOVER) begin
                     r.command = njs_pkg::CMD_START_NET;
                     r.command_arg = cfg_start_mode;
                     arm_timer(cfg_join_wait);
                  end else begin
                     r.command = njs_pkg::CMD_GET_INFO;
                     link = njs_pkg::ST_INFO;
                     arm_timer(cfg_response_wait);
                  end
               end
            end
         end
         njs_pkg::FN_RESET_IND: begin
            r.command = njs_pkg::CMD_GET_INFO;
            link = njs_pkg::ST_INFO;
            arm_timer(cfg_response_wait);
         end
         njs_pkg::FN_INFO_REPLY: begin
            if (ev.reported_type != cfg_wanted_type) begin
               r.command = njs_pkg::CMD_WRITE_TYPE;
               r.command_arg = cfg_wanted_type;
               link = njs_pkg::ST_WRITE;
               arm_timer(cfg_response_wait);
            end else if (ev.net_started == njs_pkg::NOT_STARTED) begin
               r.command = njs_pkg::CMD_START_NET;
               r.command_arg = cfg_start_mode;
               link = njs_pkg::ST_START;
               arm_timer(cfg_join_wait);
            end else begin
               id_short = ev.node_addr;
               id_ext = ev.node_mac;
               id_parent_short = ev.coord_addr;
               id_parent_ext = ev.coord_mac;
               id_channel = ev.radio_channel;
               id_pan = ev.pan_ident;
               link = njs_pkg::ST_ON_NET;
               info_valid = 1'b1;
               tmr_running = 1'b0;
               r.led = njs_pkg::LED_ON_NET;
            end
         end
         njs_pkg::FN_WRITE_REPLY: begin
            if (ev.status_code != njs_pkg::STATUS_OK)
               bump_errors();
            r.command = njs_pkg::CMD_SYS_RESET;
            link = njs_pkg::ST_IDLE;
            arm_timer(cfg_reset_wait);
         end
         njs_pkg::FN_ZDO_STATUS: begin
            if (ev.status_code == njs_pkg::STATUS_OK) begin
               r.command = njs_pkg::CMD_GET_INFO;
               link = njs_pkg::ST_INFO;
               arm_timer(cfg_response_wait);
            end else begin
               link = njs_pkg::ST_RECOVER;
               arm_timer(cfg_retry_wait);
            end
         end
         njs_pkg::FN_FACTORY_RESET: begin
            // timer deliberately untouched
            link = njs_pkg::ST_IDLE;
            info_valid = 1'b0;
            r.led = njs_pkg::LED_FACTORY;
         end
         njs_pkg::FN_RESTART: begin
            link = njs_pkg::ST_IDLE;
            info_valid = 1'b0;
            err_count = '0;
            r.command = njs_pkg::CMD_SYS_RESET;
            arm_timer(cfg_reset_wait);
         end
         default: ;   // unused code: no effect
      endcase
      r.join_state = link;
      r.on_net = (link == njs_pkg::ST_ON_NET) && info_valid;
      r.error_count = err_count;
      r.my_short = id_short;
      r.my_ext = id_ext;
      r.parent_short = id_parent_short;
      r.parent_ext = id_parent_ext;
      r.channel = id_channel;
      r.pan = id_pan;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Event builders
   // ---------------------------------------------------------------
   function automatic join_event_type make_event(input logic [2:0] func,
                                                 input logic [7:0] rtype,
                                                 input logic [7:0] started,
                                                 input logic [7:0] status,
                                                 input logic fill);
      join_event_type ev;
      ev.func = func;
      ev.reported_type = rtype;
      ev.net_started = started;
      ev.status_code = status;
      ev.node_addr = {16{fill}};
      ev.node_mac = {64{fill}};
      ev.coord_addr = {16{fill}};
      ev.coord_mac = {64{fill}};
      ev.radio_channel = {8{fill}};
      ev.pan_ident = {16{fill}};
      return ev;
   endfunction

   // Mostly join traffic: ticks, replies that often match the wanted type,
   // a sprinkling of resets, restarts and the unused code.
   function automatic join_event_type random_event(input logic allow_restart);
      join_event_type ev;
      int pick;
      ev.reported_type = ($urandom_range(0, 99) < 60) ? cfg_wanted_type
                                                       : 8'($urandom_range(0, 255));
      ev.net_started = ($urandom_range(0, 99) < 35) ? njs_pkg::NOT_STARTED
                                                     : 8'($urandom_range(0, 255));
      ev.status_code = ($urandom_range(0, 1) == 0) ? njs_pkg::STATUS_OK
                                                    : 8'($urandom_range(0, 255));
      ev.node_addr = 16'($urandom_range(0, 65535));
      ev.node_mac = {$urandom, $urandom};
      ev.coord_addr = 16'($urandom_range(0, 65535));
      ev.coord_mac = {$urandom, $urandom};
      ev.radio_channel = 8'($urandom_range(0, 255));
      ev.pan_ident = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 40)
         ev.func = njs_pkg::FN_TICK;
      else if (pick < 48)
         ev.func = njs_pkg::FN_RESET_IND;
      else if (pick < 66)
         ev.func = njs_pkg::FN_INFO_REPLY;
      else if (pick < 76)
         ev.func = njs_pkg::FN_WRITE_REPLY;
      else if (pick < 88)
         ev.func = njs_pkg::FN_ZDO_STATUS;
      else if (pick < 92)
         ev.func = njs_pkg::FN_FACTORY_RESET;
      else if (pick < 96)
         ev.func = allow_restart ? njs_pkg::FN_RESTART : njs_pkg::FN_TICK;
      else
         ev.func = FN_UNUSED;
      return ev;
   endfunction

   // ---------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------
   // Offer one beat, hold it until accepted, then log its expected response.
   task automatic send_event(input join_event_type ev);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= ev.func;
      req_reported_type <= ev.reported_type;
      req_net_started <= ev.net_started;
      req_node_addr <= ev.node_addr;
      req_node_mac <= ev.node_mac;
      req_coord_addr <= ev.coord_addr;
      req_coord_mac <= ev.coord_mac;
      req_radio_channel <= ev.radio_channel;
      req_pan_ident <= ev.pan_ident;
      req_status_code <= ev.status_code;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_reports.push_back(advance_join(ev));
      events_sent++;
   endtask

   // Stop offering and wait until every response is in; block is idle after.
   task automatic drain_reports();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Register write; only called with nothing outstanding.
   task automatic write_csr(input logic [2:0] index, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         njs_pkg::REG_WANTED_TYPE:   cfg_wanted_type = value[7:0];
         njs_pkg::REG_RESPONSE_WAIT: cfg_response_wait = value;
         njs_pkg::REG_RESET_WAIT:    cfg_reset_wait = value;
         njs_pkg::REG_JOIN_WAIT:     cfg_join_wait = value;
         njs_pkg::REG_RETRY_WAIT:    cfg_retry_wait = value;
         njs_pkg::REG_RETRY_LIMIT:   cfg_retry_limit = value[7:0];
         njs_pkg::REG_START_MODE:    cfg_start_mode = value[7:0];
         default: ;
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_config(input logic [7:0] wanted, input logic [15:0] rsp_wait,
                              input logic [15:0] rst_wait, input logic [15:0] jn_wait,
                              input logic [15:0] rty_wait, input logic [7:0] limit,
                              input logic [7:0] mode);
      write_csr(njs_pkg::REG_WANTED_TYPE, {8'h00, wanted});
      write_csr(njs_pkg::REG_RESPONSE_WAIT, rsp_wait);
      write_csr(njs_pkg::REG_RESET_WAIT, rst_wait);
      write_csr(njs_pkg::REG_JOIN_WAIT, jn_wait);
      write_csr(njs_pkg::REG_RETRY_WAIT, rty_wait);
      write_csr(njs_pkg::REG_RETRY_LIMIT, {8'h00, limit});
      write_csr(njs_pkg::REG_START_MODE, {8'h00, mode});
   endtask

   // Receiver: random stalls, plus the long hold when requested.
   always @(posedge clock)
      rsp_stall <= hold_active || ($urandom_range(0, 99) < stall_pct);

   // Long hold-off, counted here so the sender keeps running meanwhile.
   always begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // ---------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------
   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      join_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: response beat with none outstanding, expected nothing, actual cmd %h",
                     $time, rsp_command);
            failures++;
         end else begin
            want = pending_reports.pop_front();
            check_field("command", 64'(want.command), 64'(rsp_command));
            check_field("command_arg", 64'(want.command_arg), 64'(rsp_command_arg));
            check_field("led_pattern", 64'(want.led), 64'(rsp_led_pattern));
            check_field("join_state", 64'(want.join_state), 64'(rsp_join_state));
            check_field("on_net", 64'(want.on_net), 64'(rsp_on_net));
            check_field("error_count", 64'(want.error_count), 64'(rsp_error_count));
            check_field("my_short_addr", 64'(want.my_short), 64'(rsp_my_short_addr));
            check_field("my_ext_addr", want.my_ext, rsp_my_ext_addr);
            check_field("parent_short_addr", 64'(want.parent_short),
                        64'(rsp_parent_short_addr));
            check_field("parent_ext_addr", want.parent_ext, rsp_parent_ext_addr);
            check_field("chan_out", 64'(want.channel), 64'(rsp_chan_out));
            check_field("pan_out", 64'(want.pan), 64'(rsp_pan_out));
            reports_checked++;
            if (want.on_net)
               on_net_reports++;
            if (want.led == njs_pkg::LED_FAILURE)
               give_up_reports++;
            if (int'(want.error_count) > peak_errors)
               peak_errors = int'(want.error_count);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("network_join_sequencer verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Walk the join flow by hand: retries, give-up, write failure,
   // recover path, on-net latch, stopped timer, factory reset, unused code,
   // zero wait value.
   task automatic test_directed();
      load_config(8'hA5, 16'd2, 16'hFFFF, 16'd3, 16'd1, 8'd1, 8'hFF);
      // timer from reset
      send_event(make_event(njs_pkg::FN_TICK, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      // no effect
      send_event(make_event(FN_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_event(make_event(njs_pkg::FN_RESET_IND, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      send_event(make_event(njs_pkg::FN_TICK, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      // expiry, retry
      send_event(make_event(njs_pkg::FN_TICK, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      // wrong type
      send_event(make_event(njs_pkg::FN_INFO_REPLY, 8'h00, 8'hFF, njs_pkg::STATUS_OK, 1'b1));
      // write failed
      send_event(make_event(njs_pkg::FN_WRITE_REPLY, 8'h00, 8'h00, 8'hFF, 1'b0));
      send_event(make_event(njs_pkg::FN_RESET_IND, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      send_event(make_event(njs_pkg::FN_INFO_REPLY, 8'hA5, njs_pkg::NOT_STARTED,
                            njs_pkg::STATUS_OK, 1'b1));
      // give up
      repeat (3)
         send_event(make_event(njs_pkg::FN_TICK, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      send_event(make_event(njs_pkg::FN_RESTART, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      // recover
      send_event(make_event(njs_pkg::FN_ZDO_STATUS, 8'h00, 8'h00, 8'h80, 1'b0));
      // start retry
      send_event(make_event(njs_pkg::FN_TICK, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      send_event(make_event(njs_pkg::FN_ZDO_STATUS, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      // on net, all ones
      send_event(make_event(njs_pkg::FN_INFO_REPLY, 8'hA5, 8'hFF, njs_pkg::STATUS_OK, 1'b1));
      // timer stopped
      send_event(make_event(njs_pkg::FN_TICK, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      send_event(make_event(njs_pkg::FN_FACTORY_RESET, 8'h00, 8'h00,
                            njs_pkg::STATUS_OK, 1'b0));
      // on net, zeros
      send_event(make_event(njs_pkg::FN_INFO_REPLY, 8'hA5, 8'h01, njs_pkg::STATUS_OK, 1'b0));
      drain_reports();
      // zero load must expire on the first tick
      write_csr(njs_pkg::REG_RESPONSE_WAIT, 16'd0);
      write_csr(njs_pkg::REG_RETRY_LIMIT, 16'd254);
      send_event(make_event(njs_pkg::FN_RESET_IND, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      send_event(make_event(njs_pkg::FN_TICK, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      send_event(make_event(njs_pkg::FN_TICK, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      send_event(make_event(njs_pkg::FN_WRITE_REPLY, 8'h00, 8'h00, njs_pkg::STATUS_OK, 1'b0));
      drain_reports();
   endtask

   task automatic run_random(input int count);
      repeat (count)
         send_event(random_event(1'b1));
      drain_reports();
   endtask

   // sender busy, receiver mostly stalled; low extremes of type and mode
   task automatic test_receiver_stalls();
      load_config(8'h00, 16'd3, 16'd4, 16'd5, 16'd2, 8'd6, 8'h00);
      run_random(150);
   endtask

   // sender mostly idle, receiver ready; upper extremes, immediate give-up
   task automatic test_sender_gaps();
      send_idle_pct = 72;
      stall_pct = 6;
      load_config(8'hFF, 16'd1, 16'd2, 16'hFFFF, 16'd1, 8'd0, 8'hFF);
      run_random(150);
   endtask

   // full rate, a long response hold that fills the block, then a pause
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      load_config(8'($urandom_range(0, 255)), 16'($urandom_range(1, 16)),
                  16'($urandom_range(1, 16)), 16'($urandom_range(1, 16)),
                  16'($urandom_range(1, 16)), 8'($urandom_range(0, 30)),
                  8'($urandom_range(0, 255)));
      repeat (40)
         send_event(random_event(1'b1));
      -> hold_go;
      repeat (60)
         send_event(random_event(1'b1));
      drain_reports();
      repeat (50)
         send_event(random_event(1'b1));
      drain_reports();
   endtask

   // no restarts, mostly failed writes: error count must stick at its top
   task automatic test_error_saturation();
      load_config(8'h3C, 16'd1, 16'd1, 16'd1, 16'd1, 8'd254, 8'h5A);
      repeat (300) begin
         if ($urandom_range(0, 9) != 0)
            send_event(make_event(njs_pkg::FN_WRITE_REPLY, 8'($urandom_range(0, 255)),
                                  8'h00, 8'($urandom_range(1, 255)), 1'b0));
         else
            send_event(random_event(1'b0));
      end
      drain_reports();
   endtask

   initial begin
      reset_sequencer_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_receiver_stalls();
      test_sender_gaps();
      test_backpressure();
      test_error_saturation();

      repeat (5) @(posedge clock);
      $display("Covered %0d request beats and %0d response beats: directed join flow,",
               events_sent, reports_checked);
      $display("  both idling mixes, a long hold, saturation; %0d on-net, %0d give-ups, peak %0d",
               on_net_reports, give_up_reports, peak_errors);
      if (failures == 0)
         $display("network_join_sequencer verification clean");
      else
         $display("network_join_sequencer verification failed");
      $finish;
   end

endmodule
